### rtl/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette colour match unit.
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int CHAN_W     = 8;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int DIST_W     = 18;
  localparam int MAX_SEARCH = 256;

  localparam logic [DIST_W-1:0] DIST_START = {DIST_W{1'b1}};
  localparam logic [CNT_W-1:0]  ACTIVE_RST = 9'd256;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CNT_W-1:0]  remaining;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
    logic              exact;
    logic              done;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } wr_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### rtl/npcm_ifs.sv
// ----------------------------------------------------------------------------
// npcm interfaces
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface npcm_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, req_type, entry_index, red, green, blue, input ready);
  modport sink   (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

interface npcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] best_index;
  logic       exact_match;
  modport source (output valid, best_index, exact_match, input ready);
  modport sink   (input valid, best_index, exact_match, output ready);
endinterface

interface npcm_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] active_entries;
  modport source (output valid, active_entries, input ready);
  modport sink   (input valid, active_entries, output ready);
endinterface

### rtl/nearest_palette_color_match_unit.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match_unit
// Palette store and nearest-colour search built as a row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request channel. req_type load writes entry_index with the RGB
//            colour and returns nothing. req_type query carries an RGB
//            colour and returns one result.
//   out_ch : result channel, best_index and exact_match from a registered
//            output stage.
//   cfg_ch : write of active_entries, always ready; write only while idle.
// Each palette entry lives in its own cell. A query token enters the first
// cell and moves one cell per cycle while the row is not held, comparing
// against that cell's entry. The request channel is ready again in the
// same cycle as the result appears on out_ch. A load does not block the
// request channel. The length of the row sets how long a query takes.
// Reset clears the token valids, the output valid and active_entries (256);
// palette entries hold garbage until loaded. If the receiver stalls with a
// result waiting, the following query is accepted and its token halts at
// the end of the row until the output stage frees.
// ----------------------------------------------------------------------------
module nearest_palette_color_match_unit #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  npcm_in_if.sink     in_ch,
  npcm_out_if.source  out_ch,
  npcm_cfg_if.sink    cfg_ch
);

  localparam int NCELL = (PALETTE_DEPTH < npcm_pkg::MAX_SEARCH) ?
                         PALETTE_DEPTH : npcm_pkg::MAX_SEARCH;

  logic [npcm_pkg::CNT_W-1:0] active_r;
  logic [npcm_pkg::CNT_W-1:0] count;
  logic                       busy_r;
  logic                       out_valid_r;
  logic [npcm_pkg::IDX_W-1:0] out_best_r;
  logic                       out_exact_r;
  logic                       in_xfer;
  logic                       query_xfer;
  logic                       advance;
  logic                       finish;
  npcm_pkg::wr_t              wr;
  logic                       valid_w [NCELL+1];
  npcm_pkg::tok_t             tok_w   [NCELL+1];

  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign query_xfer = in_xfer && (in_ch.req_type == npcm_pkg::REQ_QUERY);
  assign in_ch.ready  = !busy_r;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (active_r == '0) begin
      count = npcm_pkg::CNT_W'(1);
    end else if (active_r > npcm_pkg::CNT_W'(NCELL)) begin
      count = npcm_pkg::CNT_W'(NCELL);
    end else begin
      count = active_r;
    end
  end

  always_comb begin
    wr.en    = in_xfer && (in_ch.req_type == npcm_pkg::REQ_LOAD);
    wr.idx   = in_ch.entry_index;
    wr.red   = in_ch.red;
    wr.green = in_ch.green;
    wr.blue  = in_ch.blue;
  end

  always_comb begin
    valid_w[0]           = query_xfer;
    tok_w[0].red         = in_ch.red;
    tok_w[0].green       = in_ch.green;
    tok_w[0].blue        = in_ch.blue;
    tok_w[0].remaining   = count;
    tok_w[0].best_dist   = npcm_pkg::DIST_START;
    tok_w[0].best_idx    = '0;
    tok_w[0].exact       = 1'b0;
    tok_w[0].done        = 1'b0;
  end

  // hold the whole row while a finished token cannot leave
  assign advance = !(valid_w[NCELL] && out_valid_r && !out_ch.ready);
  assign finish  = valid_w[NCELL] && advance;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    npcm_cell #(.CELL_IDX(i)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .advance     (advance),
      .wr          (wr),
      .tok_valid   (valid_w[i]),
      .tok_in      (tok_w[i]),
      .tok_valid_r (valid_w[i+1]),
      .tok_r       (tok_w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= npcm_pkg::ACTIVE_RST;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        active_r <= cfg_ch.active_entries;
      end
      if (query_xfer) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_best_r  <= tok_w[NCELL].best_idx;
      out_exact_r <= tok_w[NCELL].exact;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.best_index  = out_best_r;
  assign out_ch.exact_match = out_exact_r;

endmodule

### rtl/npcm_cell.sv
// ----------------------------------------------------------------------------
// npcm_cell
// One palette entry plus one step of the search token's walk along the row.
// ----------------------------------------------------------------------------
module npcm_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  npcm_pkg::wr_t      wr,
  input  logic               tok_valid,
  input  npcm_pkg::tok_t     tok_in,
  output logic               tok_valid_r,
  output npcm_pkg::tok_t     tok_r
);

  logic [23:0]                   entry_r;
  npcm_pkg::tok_t                tok_nxt;
  logic [npcm_pkg::CHAN_W-1:0]   dr, dg, db;
  logic [2*npcm_pkg::CHAN_W-1:0] sr, sg, sb;
  logic [npcm_pkg::DIST_W-1:0]   sq_sum;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == npcm_pkg::IDX_W'(CELL_IDX))) begin
      entry_r <= {wr.red, wr.green, wr.blue};
    end
  end

  always_comb begin
    dr     = npcm_pkg::abs_diff(tok_in.red,   entry_r[23:16]);
    dg     = npcm_pkg::abs_diff(tok_in.green, entry_r[15:8]);
    db     = npcm_pkg::abs_diff(tok_in.blue,  entry_r[7:0]);
    sr     = 16'(dr) * 16'(dr);
    sg     = 16'(dg) * 16'(dg);
    sb     = 16'(db) * 16'(db);
    sq_sum = npcm_pkg::DIST_W'(sr) + npcm_pkg::DIST_W'(sg) + npcm_pkg::DIST_W'(sb);
    tok_nxt = tok_in;
    if (!tok_in.done) begin
      if (sq_sum == '0) begin
        tok_nxt.best_idx = npcm_pkg::IDX_W'(CELL_IDX);
        tok_nxt.exact    = 1'b1;
        tok_nxt.done     = 1'b1;
      end else if (sq_sum < tok_in.best_dist) begin
        tok_nxt.best_dist = sq_sum;
        tok_nxt.best_idx  = npcm_pkg::IDX_W'(CELL_IDX);
      end
      if (tok_in.remaining == npcm_pkg::CNT_W'(1)) begin
        tok_nxt.done = 1'b1;
      end
      tok_nxt.remaining = tok_in.remaining - npcm_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else if (advance) begin
      tok_valid_r <= tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

### rtl/npcm_checker.sv
// ----------------------------------------------------------------------------
// npcm_checker
// Port-level checks for the nearest palette colour match unit.
// ----------------------------------------------------------------------------
module npcm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_best_index,
  input logic       out_exact_match
);

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_best_index) && $stable(out_exact_match))
    else $error("stalled result changed");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == npcm_pkg::REQ_QUERY) |=> !in_ready)
    else $error("request taken during a search");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == npcm_pkg::REQ_LOAD) |=> in_ready)
    else $error("load transfer blocked the request channel");

endmodule

bind nearest_palette_color_match_unit npcm_checker u_npcm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_req_type     (in_ch.req_type),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_best_index  (out_ch.best_index),
  .out_exact_match (out_ch.exact_match)
);
